FILE: rtl/core/stf_pkg.sv
// ----------------------------------------------------------------------------
// stf_pkg
// Shared types, codes and constants of the SOF timeline fit core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stf_pkg;

  localparam int DEF_SAMPLE_DEPTH = 128;
  localparam int DEF_DECIMATION   = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SOF_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOF_DELAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEAD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEAD   = 3'd5;

  localparam logic [3:0]  RST_SOF_STEP  = 4'd1;
  localparam logic [9:0]  RST_SOF_DELAY = 10'd0;
  localparam logic [15:0] RST_NOMINAL   = 16'd3000;
  localparam logic [15:0] RST_PULSE_W   = 16'd240;
  localparam logic [15:0] RST_MIN_LEAD  = 16'd16;
  localparam logic [15:0] RST_MAX_LEAD  = 16'd8000;

  localparam logic [1:0] REQ_SOF   = 2'd0;
  localparam logic [1:0] REQ_FIT   = 2'd1;
  localparam logic [1:0] REQ_SCHED = 2'd2;
  localparam logic [1:0] REQ_CAP   = 2'd3;

  localparam int MIN_FIT_SAMPLES = 32;
  localparam int LIM_LO_PCT      = 99;
  localparam int LIM_HI_PCT      = 101;
  localparam int PCT_SCALE       = 100;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 168;

  // datapath operations
  localparam logic [3:0] OP_NONE        = 4'd0;
  localparam logic [3:0] OP_LOAD        = 4'd1;
  localparam logic [3:0] OP_SOF         = 4'd2;
  localparam logic [3:0] OP_FIT_INIT    = 4'd3;
  localparam logic [3:0] OP_ACC         = 4'd4;
  localparam logic [3:0] OP_SLOPE_DIV   = 4'd5;
  localparam logic [3:0] OP_SLOPE_CHK   = 4'd6;
  localparam logic [3:0] OP_FIT_COMMIT  = 4'd7;
  localparam logic [3:0] OP_SCHED_START = 4'd8;
  localparam logic [3:0] OP_SCHED_LEAD  = 4'd9;
  localparam logic [3:0] OP_MUL_HI      = 4'd10;
  localparam logic [3:0] OP_SCHED_FIN   = 4'd11;
  localparam logic [3:0] OP_CAP_START   = 4'd12;
  localparam logic [3:0] OP_CAP_FIN     = 4'd13;
  localparam logic [3:0] OP_PUSH        = 4'd14;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       fit_short;
    logic       acc_last;
    logic       slope_bad;
    logic       no_line;
    logic       div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sof_timeline_fit_and_pulse_scheduler_core.sv
// ----------------------------------------------------------------------------
// sof_timeline_fit_and_pulse_scheduler_core
// Maps a free-running counter onto the USB microframe timeline.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream, one transfer each, with the request kind
// on s_tuser (SOF sample, fit, schedule pulse, convert capture). Every
// request returns exactly one result transfer on the m_ stream.
// Requests are processed one at a time by a sequencer and a shared
// one-bit-per-cycle 64-bit divider:
//   SOF sample      no divide
//   fit             ring read, two divides
//   schedule pulse  one divide, two 32x32 multiplies
//   capture         one divide
//   short fit / no line: no divide
// A new request is taken while the last result still waits in the output
// register; a stalled receiver holds the result and blocks only the push of
// the next one. Reset restores the register defaults, clears the timeline
// and drops the fit; the sample ring needs no clearing pass since only
// entries written since the last restart are read.
// Configuration writes (cfg_we) are taken at any cycle, meant while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sof_timeline_fit_and_pulse_scheduler_core import stf_pkg::*; #(
  parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH,
  parameter int DECIMATION   = DEF_DECIMATION
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  wire  [IN_DATA_W-1:0]  s_tdata,   // microframe[63:0], count_value[95:64]
  input  wire  [1:0]            s_tuser,   // req_type[1:0]
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // ok[0], rise_compare[32:1],
                                           // fall_compare[64:33],
                                           // capture_microframe_q16[128:65],
                                           // slope_out[160:129], zero pad
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  stf_dp #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .DECIMATION   (DECIMATION)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_type   (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/core/stf_div.sv
// ----------------------------------------------------------------------------
// stf_div
// Shared restoring divider, one quotient bit per cycle, sign applied at end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stf_div import stf_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [63:0] num,
  input  wire  [63:0] den,
  input  wire         neg,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] n_sh;
  logic [63:0] q_sh;
  logic [64:0] rem;
  logic [63:0] d_r;
  logic        neg_r;
  logic [64:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem[63:0], n_sh[63]};
    fits  = trial >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 7'd0;
        n_sh  <= num;
        d_r   <= den;
        neg_r <= neg;
        rem   <= '0;
        q_sh  <= '0;
      end else if (busy) begin
        n_sh <= {n_sh[62:0], 1'b0};
        rem  <= fits ? trial - {1'b0, d_r} : trial;
        q_sh <= {q_sh[62:0], fits};
        cnt  <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= neg_r ? -{q_sh[62:0], fits} : {q_sh[62:0], fits};
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/stf_dp.sv
// ----------------------------------------------------------------------------
// stf_dp
// Datapath: config, sample ring, fit accumulators, line state and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stf_dp import stf_pkg::*; #(
  parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH,
  parameter int DECIMATION   = DEF_DECIMATION
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data,
  input  wire  [1:0]            in_type,
  input  wire  [IN_DATA_W-1:0]  in_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int HW    = $clog2(SAMPLE_DEPTH);
  localparam int FW    = $clog2(SAMPLE_DEPTH + 1);
  localparam int DW    = $clog2(DECIMATION + 1);
  localparam int OW    = FW + DW;
  localparam logic [63:0] DEC64 = 64'(DECIMATION);
  localparam logic [FW:0] DEPTH_X = (FW + 1)'(SAMPLE_DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(SAMPLE_DEPTH);
  localparam logic [HW-1:0] LAST_ADDR = HW'(SAMPLE_DEPTH - 1);

  // config
  logic [3:0]  sof_step;
  logic [9:0]  sof_delay;
  logic [15:0] nominal;
  logic [15:0] pulse_w;
  logic [15:0] min_lead;
  logic [15:0] max_lead;

  // current item
  logic [1:0]  typ;
  logic [63:0] frame;
  logic [31:0] cnt;

  // timeline state
  logic [HW-1:0] head;
  logic [FW-1:0] fill;
  logic [63:0]   base_frame;
  logic [63:0]   next_frame;
  logic [63:0]   prev_frame;
  logic          started;
  logic          line_valid;
  logic [63:0]   lref_frame;
  logic [63:0]   lref_q16;
  logic [31:0]   lslope;

  logic [31:0]   ring [SAMPLE_DEPTH];
  logic [HW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          wr_en;
  logic [HW-1:0] wr_addr;
  logic [31:0]   wr_data;

  // fit scratch
  logic [FW-1:0]     count_r;
  logic [FW-1:0]     half_r;
  logic [2*FW-1:0]   half_sq;
  logic [OW-1:0]     offs;
  logic [FW-1:0]     idx;
  logic [31:0]       origin;
  logic signed [63:0] lo_sum;
  logic signed [63:0] hi_sum;
  logic [31:0]       slope_r;
  logic [63:0]       prod;

  // schedule scratch
  logic [63:0] ahead;
  logic        lead_ok;
  logic [63:0] pp_lo;
  logic [63:0] pp_hi;

  // result
  logic        res_ok;
  logic [31:0] res_rise;
  logic [31:0] res_fall;
  logic [63:0] res_cap;

  logic        o_ok;
  logic [31:0] o_rise;
  logic [31:0] o_fall;
  logic [63:0] o_cap;
  logic [31:0] o_slope;

  // shared units
  logic        div_start;
  logic [63:0] div_num;
  logic [63:0] div_den;
  logic        div_done;
  logic [63:0] div_q;
  logic signed [63:0] div_s;
  logic [63:0] div_mag;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // combinational helpers
  logic [31:0]   ticks;
  logic          consec;
  logic [FW:0]   wr_sum;
  logic [FW-1:0] count_c;
  logic [31:0]   ref_int;
  logic signed [63:0] diff_sx;
  logic signed [63:0] dq;
  logic signed [63:0] v;
  logic [40:0]   lo_x;
  logic [40:0]   hi_x;
  logic [40:0]   s_lo;
  logic [40:0]   s_hi;
  logic signed [63:0] lead;
  logic [63:0]   tq;
  logic [31:0]   target;
  logic [63:0]   absq;

  always_comb begin
    ticks   = cnt - {22'd0, sof_delay};
    consec  = started && (frame == prev_frame + {60'd0, sof_step});
    wr_sum  = (FW + 1)'(head) + (FW + 1)'(fill);
    if (wr_sum >= DEPTH_X) begin
      wr_sum = wr_sum - DEPTH_X;
    end
    count_c = {fill[FW-1:1], 1'b0};
    ref_int = lref_q16[47:16];
    diff_sx = 64'(signed'(cnt - ref_int));
    dq      = (diff_sx <<< 16) - $signed({48'd0, lref_q16[15:0]});
    v       = (idx == '0) ? 64'sd0 : 64'(signed'(rd_data - origin));
    lo_x    = 41'({nominal, 16'd0}) * 41'(LIM_LO_PCT);
    hi_x    = 41'({nominal, 16'd0}) * 41'(LIM_HI_PCT);
    s_lo    = (41'(div_q[31:0]) + 41'd1) * 41'(PCT_SCALE);
    s_hi    = 41'(div_q[31:0]) * 41'(PCT_SCALE);
    lead    = $signed(ahead - div_q);
    tq      = lref_q16 + pp_lo + {pp_hi[31:0], 32'd0};
    target  = tq[47:16];
    absq    = {lref_frame[47:0], 16'd0} + div_q;
  end

  // status toward the controller
  always_comb begin
    stat.req_type  = typ;
    stat.fit_short = count_c < FW'(MIN_FIT_SAMPLES);
    stat.acc_last  = idx == count_r - FW'(1);
    stat.slope_bad = div_q[63] || (div_q == 64'd0) || (div_q[62:32] != '0) ||
                     (s_lo <= lo_x) || (s_hi > hi_x);
    stat.no_line   = !(line_valid && (lslope != 32'd0));
    stat.div_done  = div_done;
  end

  // divider operand select
  always_comb begin
    div_s     = 64'sd0;
    div_den   = 64'd1;
    div_start = 1'b0;
    unique case (cmd.op)
      OP_SLOPE_DIV: begin
        div_s     = hi_sum - lo_sum;
        div_den   = 64'(half_sq) * DEC64;
        div_start = 1'b1;
      end
      OP_SLOPE_CHK: begin
        div_s     = hi_sum + lo_sum;
        div_den   = 64'(count_r);
        div_start = !stat.slope_bad;
      end
      OP_SCHED_START: begin
        div_s     = diff_sx;
        div_den   = {32'd0, lslope};
        div_start = 1'b1;
      end
      OP_CAP_START: begin
        div_s     = dq;
        div_den   = {32'd0, lslope};
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
    div_mag = div_s[63] ? 64'(-div_s) : 64'(div_s);
    div_num = {div_mag[47:0], 16'd0};
  end

  stf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .neg   (div_s[63]),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    mul_a = lslope;
    mul_b = ahead[31:0];
    unique case (cmd.op)
      OP_SLOPE_CHK: begin
        mul_a = div_q[31:0];
        mul_b = 32'(offs);
      end
      OP_MUL_HI: begin
        mul_b = ahead[63:32];
      end
      default: begin
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // sample ring
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_sum[HW-1:0];
    wr_data = ticks;
    if (cmd.op == OP_SOF) begin
      if (!consec) begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end else if (frame == next_frame) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    rd_data <= ring[rd_addr];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sof_step  <= RST_SOF_STEP;
      sof_delay <= RST_SOF_DELAY;
      nominal   <= RST_NOMINAL;
      pulse_w   <= RST_PULSE_W;
      min_lead  <= RST_MIN_LEAD;
      max_lead  <= RST_MAX_LEAD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOF_STEP:  sof_step  <= cfg_data[3:0];
        REG_SOF_DELAY: sof_delay <= cfg_data[9:0];
        REG_NOMINAL:   nominal   <= cfg_data;
        REG_PULSE_W:   pulse_w   <= cfg_data;
        REG_MIN_LEAD:  min_lead  <= cfg_data;
        REG_MAX_LEAD:  max_lead  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // timeline state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      fill       <= '0;
      base_frame <= '0;
      next_frame <= '0;
      prev_frame <= '0;
      started    <= 1'b0;
      line_valid <= 1'b0;
      lref_frame <= '0;
      lref_q16   <= '0;
      lslope     <= '0;
    end else begin
      if (cmd.op == OP_SOF) begin
        prev_frame <= frame;
        if (!consec) begin
          started    <= 1'b1;
          head       <= '0;
          fill       <= FW'(1);
          base_frame <= frame;
          next_frame <= frame + DEC64;
          line_valid <= 1'b0;
        end else if (frame == next_frame) begin
          next_frame <= next_frame + DEC64;
          if (fill < DEPTH_F) begin
            fill <= fill + FW'(1);
          end else begin
            head       <= (head == LAST_ADDR) ? '0 : head + HW'(1);
            base_frame <= base_frame + DEC64;
          end
        end
      end
      if (cmd.op == OP_FIT_COMMIT) begin
        line_valid <= 1'b1;
        lref_frame <= base_frame;
        lref_q16   <= {16'd0, origin, 16'd0} + div_q - {1'b0, prod[63:1]};
        lslope     <= slope_r;
      end
    end
  end

  // item, scratch and result registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        typ      <= in_type;
        frame    <= in_data[63:0];
        cnt      <= in_data[95:64];
        res_ok   <= 1'b0;
        res_rise <= '0;
        res_fall <= '0;
        res_cap  <= '0;
      end
      OP_SOF: begin
        res_ok <= 1'b1;
      end
      OP_FIT_INIT: begin
        count_r <= count_c;
        half_r  <= fill >> 1;
        half_sq <= (2 * FW)'(fill >> 1) * (2 * FW)'(fill >> 1);
        offs    <= OW'(DECIMATION) * OW'(count_c - FW'(1));
        idx     <= '0;
        rd_addr <= head;
        lo_sum  <= '0;
        hi_sum  <= '0;
      end
      OP_ACC: begin
        if (idx == '0) begin
          origin <= rd_data;
        end
        if (idx < half_r) begin
          lo_sum <= lo_sum + v;
        end else begin
          hi_sum <= hi_sum + v;
        end
        idx     <= idx + FW'(1);
        rd_addr <= (rd_addr == LAST_ADDR) ? '0 : rd_addr + HW'(1);
      end
      OP_SLOPE_CHK: begin
        slope_r <= div_q[31:0];
        prod    <= mul_p;
      end
      OP_FIT_COMMIT: begin
        res_ok <= 1'b1;
      end
      OP_SCHED_START: begin
        ahead <= frame - lref_frame;
      end
      OP_SCHED_LEAD: begin
        lead_ok <= (lead >= $signed({48'd0, min_lead})) &&
                   (lead <= $signed({48'd0, max_lead}));
        pp_lo   <= mul_p;
      end
      OP_MUL_HI: begin
        pp_hi <= mul_p;
      end
      OP_SCHED_FIN: begin
        if (lead_ok) begin
          res_ok   <= 1'b1;
          res_rise <= target;
          res_fall <= target + {16'd0, pulse_w};
        end
      end
      OP_CAP_FIN: begin
        if (!absq[63]) begin
          res_ok  <= 1'b1;
          res_cap <= absq;
        end
      end
      OP_PUSH: begin
        o_ok    <= res_ok;
        o_rise  <= res_rise;
        o_fall  <= res_fall;
        o_cap   <= res_cap;
        o_slope <= line_valid ? lslope : 32'd0;
      end
      default: begin
      end
    endcase
  end

  assign out_data = {7'd0, o_slope, o_cap, o_fall, o_rise, o_ok};

endmodule

`default_nettype wire

FILE: rtl/core/stf_ctrl.sv
// ----------------------------------------------------------------------------
// stf_ctrl
// Sequencer: dispatches each request and steps the datapath through it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stf_ctrl import stf_pkg::*; (
  input  wire      clk,
  input  wire      rst,
  input  wire      in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  wire      out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_SOF   = 5'd2;
  localparam logic [4:0] S_FINIT = 5'd3;
  localparam logic [4:0] S_FRW   = 5'd4;
  localparam logic [4:0] S_FACC  = 5'd5;
  localparam logic [4:0] S_FSD   = 5'd6;
  localparam logic [4:0] S_FSW   = 5'd7;
  localparam logic [4:0] S_FCHK  = 5'd8;
  localparam logic [4:0] S_FMW   = 5'd9;
  localparam logic [4:0] S_FCOM  = 5'd10;
  localparam logic [4:0] S_TST   = 5'd11;
  localparam logic [4:0] S_TW    = 5'd12;
  localparam logic [4:0] S_TLEAD = 5'd13;
  localparam logic [4:0] S_TMH   = 5'd14;
  localparam logic [4:0] S_TFIN  = 5'd15;
  localparam logic [4:0] S_CST   = 5'd16;
  localparam logic [4:0] S_CW    = 5'd17;
  localparam logic [4:0] S_CFIN  = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       push;

  assign in_ready = state == S_IDLE;
  assign push     = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.req_type)
          REQ_SOF:   state_next = S_SOF;
          REQ_FIT:   state_next = S_FINIT;
          REQ_SCHED: state_next = stat.no_line ? S_OUT : S_TST;
          REQ_CAP:   state_next = stat.no_line ? S_OUT : S_CST;
          default:   state_next = S_OUT;
        endcase
      end
      S_SOF: begin
        cmd.op     = OP_SOF;
        state_next = S_OUT;
      end
      S_FINIT: begin
        cmd.op     = OP_FIT_INIT;
        state_next = stat.fit_short ? S_OUT : S_FRW;
      end
      S_FRW: begin
        state_next = S_FACC;
      end
      S_FACC: begin
        cmd.op     = OP_ACC;
        state_next = stat.acc_last ? S_FSD : S_FRW;
      end
      S_FSD: begin
        cmd.op     = OP_SLOPE_DIV;
        state_next = S_FSW;
      end
      S_FSW: begin
        if (stat.div_done) begin
          state_next = S_FCHK;
        end
      end
      S_FCHK: begin
        cmd.op     = OP_SLOPE_CHK;
        state_next = stat.slope_bad ? S_OUT : S_FMW;
      end
      S_FMW: begin
        if (stat.div_done) begin
          state_next = S_FCOM;
        end
      end
      S_FCOM: begin
        cmd.op     = OP_FIT_COMMIT;
        state_next = S_OUT;
      end
      S_TST: begin
        cmd.op     = OP_SCHED_START;
        state_next = S_TW;
      end
      S_TW: begin
        if (stat.div_done) begin
          state_next = S_TLEAD;
        end
      end
      S_TLEAD: begin
        cmd.op     = OP_SCHED_LEAD;
        state_next = S_TMH;
      end
      S_TMH: begin
        cmd.op     = OP_MUL_HI;
        state_next = S_TFIN;
      end
      S_TFIN: begin
        cmd.op     = OP_SCHED_FIN;
        state_next = S_OUT;
      end
      S_CST: begin
        cmd.op     = OP_CAP_START;
        state_next = S_CW;
      end
      S_CW: begin
        if (stat.div_done) begin
          state_next = S_CFIN;
        end
      end
      S_CFIN: begin
        cmd.op     = OP_CAP_FIN;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (push) begin
          cmd.op     = OP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_disp: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DISP)
    else $error("accepted transfer not dispatched");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_FSW || state == S_FMW || state == S_TW || state == S_CW))
    else $error("divider finished outside a wait state");

  a_push_valid: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid && state == S_IDLE)
    else $error("result push lost");

endmodule

`default_nettype wire
